@@ sv/wheel_sensor_fault_monitor_unit_defines.svh @@
// Assertion macros for the wheel sensor fault monitor.
`ifndef WHEEL_SENSOR_FAULT_MONITOR_UNIT_DEFINES_SVH
`define WHEEL_SENSOR_FAULT_MONITOR_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define WSFM_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset
`define WSFM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ sv/wsfm_pkg.sv @@
// Types and constants shared by the wheel sensor fault monitor modules.
package wsfm_pkg;

	localparam int SPEED_W  = 16;
	localparam int OMEGA_W  = 18;
	localparam int RADIUS_W = 16;
	localparam int STALE_W  = 16;
	localparam int TOTAL_W  = 32;
	localparam int COUNT_W  = 8;
	localparam int WIN_W    = 7;
	localparam int ERR_W    = 16;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 18;

	// Q8 value of 1.0 m/s
	localparam logic signed [SPEED_W:0] SPEED_ONE_Q8 = 17'sd256;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_WHEEL_RADIUS        = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_STUCK_SPEED_MIN     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_STUCK_CYCLES        = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_PLAUS_MARGIN        = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_PLAUS_CYCLES        = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_CRC_ERROR_THRESHOLD = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_OMEGA_MAX           = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_SPEED_MAX           = 3'd7;

	// Reset values of the configuration registers
	localparam logic [15:0]        RST_WHEEL_RADIUS        = 16'd19661;
	localparam logic [14:0]        RST_STUCK_SPEED_MIN     = 15'd256;
	localparam logic [7:0]         RST_STUCK_CYCLES        = 8'd10;
	localparam logic [14:0]        RST_PLAUS_MARGIN        = 15'd128;
	localparam logic [7:0]         RST_PLAUS_CYCLES        = 8'd5;
	localparam logic [15:0]        RST_CRC_ERROR_THRESHOLD = 16'd5;
	localparam logic signed [17:0] RST_OMEGA_MAX           = 18'sd76800;
	localparam logic signed [15:0] RST_SPEED_MAX           = 16'sd25600;

	typedef struct packed {
		logic [RADIUS_W-1:0]       wheel_radius;
		logic [14:0]               stuck_speed_min;
		logic [COUNT_W-1:0]        stuck_cycles;
		logic [14:0]               plausibility_margin;
		logic [COUNT_W-1:0]        plausibility_cycles;
		logic [ERR_W-1:0]          crc_error_threshold;
		logic signed [OMEGA_W-1:0] omega_max;
		logic signed [SPEED_W-1:0] speed_max;
	} wsfm_cfg_t;

	typedef struct packed {
		logic                      sample_valid;
		logic signed [SPEED_W-1:0] vehicle_speed;
		logic signed [OMEGA_W-1:0] wheel_omega;
	} wsfm_sample_t;

	typedef struct packed {
		logic range_fault;
		logic stuck_fault;
		logic implausible_fault;
	} wsfm_content_flags_t;

endpackage

@@ sv/wsfm_content_check.sv @@
// Range, stuck-value and plausibility checks with their counter state.
module wsfm_content_check import wsfm_pkg::*; #(
	parameter int OMEGA_LOWER_BOUND = 0,
	parameter int SPEED_LOWER_BOUND = 0
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  wsfm_cfg_t           cfg,
	input  wsfm_sample_t        sample,
	output wsfm_content_flags_t flags
);

	localparam logic signed [OMEGA_W-1:0] OMEGA_LO = OMEGA_W'(OMEGA_LOWER_BOUND);
	localparam logic signed [SPEED_W-1:0] SPEED_LO = SPEED_W'(SPEED_LOWER_BOUND);
	localparam int PROD_W = OMEGA_W + RADIUS_W + 1;

	logic signed [OMEGA_W-1:0] prev_omega_q;
	logic [COUNT_W-1:0]        frozen_q;
	logic [COUNT_W-1:0]        implaus_q;
	logic [COUNT_W-1:0]        frozen_d;
	logic [COUNT_W-1:0]        implaus_d;

	logic                      out_of_range;
	logic                      run_checks;
	logic signed [SPEED_W:0]   speed_ext;
	logic                      speed_gt_min;
	logic                      slow;
	logic signed [PROD_W-1:0]  surface_q24;
	logic signed [SPEED_W+1:0] speed_margin;
	logic signed [PROD_W-1:0]  limit_q24;
	logic                      too_fast;

	// Range check gates the remaining checks
	assign out_of_range = (sample.wheel_omega < OMEGA_LO) || (sample.wheel_omega > cfg.omega_max)
		|| (sample.vehicle_speed < SPEED_LO) || (sample.vehicle_speed > cfg.speed_max);
	assign run_checks = sample.sample_valid && !out_of_range;

	// Stuck detection
	assign speed_ext    = {sample.vehicle_speed[SPEED_W-1], sample.vehicle_speed};
	assign speed_gt_min = speed_ext > $signed({2'b00, cfg.stuck_speed_min});

	always_comb begin
		if ((sample.wheel_omega == prev_omega_q) && speed_gt_min) begin
			frozen_d = (frozen_q == '1) ? frozen_q : frozen_q + COUNT_W'(1);
		end else begin
			frozen_d = '0;
		end
	end

	// Plausibility: omega * radius against (speed + margin), both at Q24
	assign slow         = speed_ext < SPEED_ONE_Q8;
	assign surface_q24  = PROD_W'(sample.wheel_omega) * PROD_W'($signed({1'b0, cfg.wheel_radius}));
	assign speed_margin = {{2{sample.vehicle_speed[SPEED_W-1]}}, sample.vehicle_speed}
		+ $signed({3'b000, cfg.plausibility_margin});
	assign limit_q24    = PROD_W'({speed_margin, 16'h0000});
	assign too_fast     = surface_q24 > limit_q24;

	always_comb begin
		if (slow || !too_fast) begin
			implaus_d = '0;
		end else begin
			implaus_d = (implaus_q == '1) ? implaus_q : implaus_q + COUNT_W'(1);
		end
	end

	// Counter state moves only for in-range valid samples
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_omega_q <= '0;
			frozen_q     <= '0;
			implaus_q    <= '0;
		end else if (en && run_checks) begin
			prev_omega_q <= sample.wheel_omega;
			frozen_q     <= frozen_d;
			implaus_q    <= implaus_d;
		end
	end

	// Flags from the updated counts
	always_comb begin
		flags.range_fault       = sample.sample_valid && out_of_range;
		flags.stuck_fault       = run_checks && (frozen_d >= cfg.stuck_cycles);
		flags.implausible_fault = run_checks && !slow && (implaus_d >= cfg.plausibility_cycles);
	end

endmodule

@@ sv/wheel_sensor_fault_monitor_unit.sv @@
// Wheel sensor fault monitor top level: config registers, CRC window and item pipeline.
//
//  channel | handshake              | payload
//  --------+------------------------+------------------------------------------------
//  req     | req_valid / req_stall  | sample_valid vehicle_speed wheel_omega
//          |                        | stale_cycles crc_error_total
//  rsp     | rsp_valid / rsp_stall  | comm_timeout crc_rate_fault range_fault
//          |                        | stuck_fault implausible_fault
//  cfg     | cfg_we                 | cfg_index cfg_data
//
// One item per cycle unless rsp_stall holds the flow (input register, then result register).
// The check logic, including the 18x17 multiply, sits between those two registers.
// req_stall rises only when the input register is full and the result register is
// held by rsp_stall. Reset clears all counters and loads config register defaults.
`include "wheel_sensor_fault_monitor_unit_defines.svh"

module wheel_sensor_fault_monitor_unit import wsfm_pkg::*; #(
	parameter int CRC_WINDOW        = 100,
	parameter int WATCHDOG_LIMIT    = 5,
	parameter int OMEGA_LOWER_BOUND = 0,
	parameter int SPEED_LOWER_BOUND = 0
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [CFG_IDX_W-1:0]      cfg_index,
	input  logic [CFG_DATA_W-1:0]     cfg_data,
	input  logic                      req_valid,
	output logic                      req_stall,
	input  logic                      sample_valid,
	input  logic signed [SPEED_W-1:0] vehicle_speed,
	input  logic signed [OMEGA_W-1:0] wheel_omega,
	input  logic [STALE_W-1:0]        stale_cycles,
	input  logic [TOTAL_W-1:0]        crc_error_total,
	output logic                      rsp_valid,
	input  logic                      rsp_stall,
	output logic                      comm_timeout,
	output logic                      crc_rate_fault,
	output logic                      range_fault,
	output logic                      stuck_fault,
	output logic                      implausible_fault
);

	localparam logic [WIN_W-1:0]   WIN_LAST  = WIN_W'(CRC_WINDOW);
	localparam logic [STALE_W-1:0] WDOG_LIM  = STALE_W'(WATCHDOG_LIMIT);

	wsfm_cfg_t cfg_q;

	logic                      s1_valid_q;
	wsfm_sample_t              sample_s1;
	logic [STALE_W-1:0]        stale_s1;
	logic [TOTAL_W-1:0]        total_s1;

	logic                      load_s1;
	logic                      advance;

	logic [WIN_W-1:0]          win_cnt_q;
	logic [ERR_W-1:0]          win_err_q;
	logic [TOTAL_W-1:0]        last_total_q;
	logic [WIN_W-1:0]          win_cnt_inc;
	logic                      win_close;
	logic [WIN_W-1:0]          win_cnt_d;
	logic [ERR_W-1:0]          win_err_base;
	logic [ERR_W-1:0]          win_err_d;
	logic [TOTAL_W-1:0]        err_delta;
	logic                      total_rose;
	logic [ERR_W:0]            err_sum;
	logic                      crc_fault_d;

	wsfm_content_flags_t       content_flags;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.wheel_radius        <= RST_WHEEL_RADIUS;
			cfg_q.stuck_speed_min     <= RST_STUCK_SPEED_MIN;
			cfg_q.stuck_cycles        <= RST_STUCK_CYCLES;
			cfg_q.plausibility_margin <= RST_PLAUS_MARGIN;
			cfg_q.plausibility_cycles <= RST_PLAUS_CYCLES;
			cfg_q.crc_error_threshold <= RST_CRC_ERROR_THRESHOLD;
			cfg_q.omega_max           <= RST_OMEGA_MAX;
			cfg_q.speed_max           <= RST_SPEED_MAX;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_WHEEL_RADIUS:        cfg_q.wheel_radius        <= cfg_data[15:0];
				CFG_STUCK_SPEED_MIN:     cfg_q.stuck_speed_min     <= cfg_data[14:0];
				CFG_STUCK_CYCLES:        cfg_q.stuck_cycles        <= cfg_data[7:0];
				CFG_PLAUS_MARGIN:        cfg_q.plausibility_margin <= cfg_data[14:0];
				CFG_PLAUS_CYCLES:        cfg_q.plausibility_cycles <= cfg_data[7:0];
				CFG_CRC_ERROR_THRESHOLD: cfg_q.crc_error_threshold <= cfg_data[15:0];
				CFG_OMEGA_MAX:           cfg_q.omega_max           <= $signed(cfg_data[17:0]);
				CFG_SPEED_MAX:           cfg_q.speed_max           <= $signed(cfg_data[15:0]);
				default: ;
			endcase
		end
	end

	// Handshake: the input register drains into the result register
	assign advance   = s1_valid_q && (!rsp_valid || !rsp_stall);
	assign req_stall = s1_valid_q && !advance;
	assign load_s1   = req_valid && !req_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (load_s1) begin
			s1_valid_q <= 1'b1;
		end else if (advance) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			sample_s1.sample_valid  <= sample_valid;
			sample_s1.vehicle_speed <= vehicle_speed;
			sample_s1.wheel_omega   <= wheel_omega;
			stale_s1                <= stale_cycles;
			total_s1                <= crc_error_total;
		end
	end

	// CRC error window: close check first, then fold in new errors
	assign win_cnt_inc  = win_cnt_q + WIN_W'(1);
	assign win_close    = win_cnt_inc >= WIN_LAST;
	assign win_cnt_d    = win_close ? '0 : win_cnt_inc;
	assign win_err_base = win_close ? '0 : win_err_q;
	assign crc_fault_d  = win_close && (win_err_q >= cfg_q.crc_error_threshold);

	assign total_rose = total_s1 > last_total_q;
	assign err_delta  = total_s1 - last_total_q;
	assign err_sum    = {1'b0, win_err_base} + {1'b0, err_delta[ERR_W-1:0]};

	always_comb begin
		if (!total_rose) begin
			win_err_d = win_err_base;
		end else if ((err_delta[TOTAL_W-1:ERR_W] != '0) || err_sum[ERR_W]) begin
			win_err_d = '1;
		end else begin
			win_err_d = err_sum[ERR_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_cnt_q    <= '0;
			win_err_q    <= '0;
			last_total_q <= '0;
		end else if (advance) begin
			win_cnt_q <= win_cnt_d;
			win_err_q <= win_err_d;
			if (total_rose) begin
				last_total_q <= total_s1;
			end
		end
	end

	// Content checks
	wsfm_content_check #(
		.OMEGA_LOWER_BOUND(OMEGA_LOWER_BOUND),
		.SPEED_LOWER_BOUND(SPEED_LOWER_BOUND)
	) u_content (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (advance),
		.cfg    (cfg_q),
		.sample (sample_s1),
		.flags  (content_flags)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid <= 1'b0;
		end else if (advance) begin
			rsp_valid <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			comm_timeout      <= stale_s1 > WDOG_LIM;
			crc_rate_fault    <= crc_fault_d;
			range_fault       <= content_flags.range_fault;
			stuck_fault       <= content_flags.stuck_fault;
			implausible_fault <= content_flags.implausible_fault;
		end
	end

	// Checks
	`WSFM_ASSERT_NOW(a_range_blocks_others, clk, arst_n, rsp_valid && range_fault, !stuck_fault && !implausible_fault, "range fault with other content flag")
	`WSFM_ASSERT_NOW(a_window_bound, clk, arst_n, 1'b1, win_cnt_q < WIN_LAST, "CRC window count past window length")
	`WSFM_ASSERT_NOW(a_stall_when_full, clk, arst_n, s1_valid_q && rsp_valid && rsp_stall, req_stall, "item taken while pipeline blocked")
	`WSFM_ASSERT_NEXT(a_accept_loads, clk, arst_n, req_valid && !req_stall, s1_valid_q, "accepted item not held in input register")

endmodule
